// ===== rtl/core/phfu_pkg.sv =====
// Shared types and codes of the pipeline hazard and forwarding unit.
// Depends on nothing; every other file of the block imports it.
package phfu_pkg;

   // Hazard handling mode, as held in the mode register.
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_OFF       = 2'd0;
   localparam mode_type MODE_STALL     = 2'd1;
   localparam mode_type MODE_STALL_FWD = 2'd2;
   localparam mode_type MODE_RESET     = MODE_STALL_FWD;

   // Operand source select codes for the ALU operands.
   typedef logic [1:0] fwd_sel_type;
   localparam fwd_sel_type FWD_REGFILE = 2'd0;
   localparam fwd_sel_type FWD_MEM     = 2'd1;
   localparam fwd_sel_type FWD_EX      = 2'd2;

   typedef logic [4:0] reg_num_type;

   // Bit positions inside the decode need flags.
   localparam int NEED_ALU_A = 0;
   localparam int NEED_ALU_B = 1;
   localparam int NEED_BR_A  = 2;
   localparam int NEED_BR_B  = 3;

   // One request: decode sources plus the execute and memory stage state.
   typedef struct packed {
      reg_num_type dec_src_a;
      reg_num_type dec_src_b;
      logic [3:0]  dec_need;
      logic        ex_writes;
      reg_num_type ex_dest;
      logic        ex_is_load;
      logic        ex_stop_fetch;
      logic        mem_writes;
      reg_num_type mem_dest;
      logic        mem_is_load;
      logic        mem_stop_fetch;
   } req_type;

   // One result: stall and forwarding decisions.
   typedef struct packed {
      logic        stall_res;
      logic        branch_wait;
      fwd_sel_type fwd_sel_a;
      fwd_sel_type fwd_sel_b;
      logic        branch_fwd_a;
      logic        branch_fwd_b;
   } rsp_type;

endpackage

// ===== rtl/core/phfu_if.sv =====
// Channel interfaces of the hazard unit: request, result and mode write.
// Depends on phfu_pkg for the payload types.
interface phfu_req_if;
   import phfu_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface phfu_rsp_if;
   import phfu_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface phfu_csr_if;
   import phfu_pkg::*;
   logic     valid;
   logic     ready;
   mode_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/pipeline_hazard_forward_unit.sv =====
// Top level of the pipeline hazard and forwarding unit.
// Depends on phfu_pkg, phfu_if, phfu_mode_reg and phfu_resolve.
//
//   channel   direction  payload                       handshake
//   req_bus   in         decode and stage state        valid / ready
//   rsp_bus   out        stall and forward decisions   valid / ready
//   csr_bus   in         hazard mode (2 bits)          valid / ready (always ready)
//
// One request per cycle is taken while ready is high; its result passes through
// the request register and then the result register.
// Reset is synchronous and empties both registers; the mode returns to stall
// and forward. A stalled result holds in the result register while the request
// register still takes one more request; ready falls only when both are full.
module pipeline_hazard_forward_unit
   import phfu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   phfu_req_if.sink    req_bus,
   phfu_rsp_if.source  rsp_bus,
   phfu_csr_if.sink    csr_bus
);

   mode_type mode;
   req_type  req_data_ff;
   logic     req_valid_ff;
   logic     req_valid_in;
   rsp_type  rsp_data_ff;
   rsp_type  rsp_calc;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   logic     rsp_load;
   logic     req_load;

   phfu_mode_reg u_mode_reg (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .mode    (mode)
   );

   phfu_resolve u_resolve (
      .mode (mode),
      .req  (req_data_ff),
      .rsp  (rsp_calc)
   );

   // The result register takes a new value when empty or being emptied.
   assign rsp_load = !rsp_valid_ff || rsp_bus.ready;
   assign req_load = !req_valid_ff || rsp_load;
   assign req_bus.ready = req_load;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = req_valid_ff;
      end
      req_valid_in = req_valid_ff;
      if (req_load) begin
         req_valid_in = req_bus.valid;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_load && req_bus.valid) begin
         req_data_ff <= req_bus.data;
      end
      if (rsp_load && req_valid_ff) begin
         rsp_data_ff <= rsp_calc;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   // A branch stall is always part of a stall.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.branch_wait |-> rsp_data_ff.stall_res)
      else $error("branch stall without stall");

   // Select code three is never produced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.fwd_sel_a != 2'd3) && (rsp_data_ff.fwd_sel_b != 2'd3))
      else $error("invalid forward select");

   // A branch operand is never both forwarded and stalled on in execute.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.branch_fwd_a || rsp_data_ff.branch_fwd_b)
      |-> !rsp_data_ff.branch_wait)
      else $error("branch forward during branch stall");

   // A held request is not dropped while the result register is blocked.
   assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !rsp_load |=> req_valid_ff && $stable(req_data_ff))
      else $error("held request lost");

endmodule

// ===== rtl/core/phfu_mode_reg.sv =====
// Mode register of the hazard unit, written over the configuration channel.
// Depends on phfu_pkg and phfu_csr_if.
module phfu_mode_reg
   import phfu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   phfu_csr_if.sink  csr_bus,
   output mode_type  mode
);

   mode_type mode_ff;
   mode_type mode_in;

   // A write is always taken at once.
   assign csr_bus.ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (csr_bus.valid) begin
         mode_in = csr_bus.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign mode = mode_ff;

endmodule

// ===== rtl/core/phfu_resolve.sv =====
// Hazard detection and forward selection for one registered request.
// Depends on phfu_pkg; purely combinational.
module phfu_resolve
   import phfu_pkg::*;
(
   input  mode_type mode,
   input  req_type  req,
   output rsp_type  rsp
);

   logic active;
   logic fwd_on;
   logic ex_ok;
   logic mem_ok;
   logic m_a, m_b, e_a, e_b;
   logic be_a, be_b, bm_a, bm_b;
   logic be_any;
   logic alu_stall, br_stall;

   // A stage can supply a value only if it writes a register other than zero.
   assign ex_ok  = req.ex_writes && (req.ex_dest != '0);
   assign mem_ok = req.mem_writes && (req.mem_dest != '0);

   assign active = (mode != MODE_OFF);
   assign fwd_on = (mode == MODE_STALL_FWD);

   // Matches of each source against each stage, for ALU and branch use.
   assign m_a  = mem_ok && req.dec_need[NEED_ALU_A] && (req.mem_dest == req.dec_src_a);
   assign m_b  = mem_ok && req.dec_need[NEED_ALU_B] && (req.mem_dest == req.dec_src_b);
   assign e_a  = ex_ok && req.dec_need[NEED_ALU_A] && (req.ex_dest == req.dec_src_a);
   assign e_b  = ex_ok && req.dec_need[NEED_ALU_B] && (req.ex_dest == req.dec_src_b);
   assign bm_a = mem_ok && req.dec_need[NEED_BR_A] && (req.mem_dest == req.dec_src_a);
   assign bm_b = mem_ok && req.dec_need[NEED_BR_B] && (req.mem_dest == req.dec_src_b);
   assign be_a = ex_ok && req.dec_need[NEED_BR_A] && (req.ex_dest == req.dec_src_a);
   assign be_b = ex_ok && req.dec_need[NEED_BR_B] && (req.ex_dest == req.dec_src_b);
   assign be_any = be_a || be_b;

   // ALU operands stall when they cannot be forwarded: no forwarding at all,
   // or a load still in execute.
   assign alu_stall = (!fwd_on && (m_a || m_b))
                    || ((!fwd_on || req.ex_is_load) && (e_a || e_b));

   // Branch operands from execute always stall; from memory only when that
   // value is a load or forwarding is off.
   assign br_stall = be_any || ((!fwd_on || req.mem_is_load) && (bm_a || bm_b));

   // Operand selects: execute wins over memory unless execute holds a load.
   // Fetch-stop requests stall whatever the mode.
   always_comb begin
      rsp.fwd_sel_a = FWD_REGFILE;
      rsp.fwd_sel_b = FWD_REGFILE;
      if (active && fwd_on) begin
         if (e_a && !req.ex_is_load) begin
            rsp.fwd_sel_a = FWD_EX;
         end else if (m_a) begin
            rsp.fwd_sel_a = FWD_MEM;
         end
         if (e_b && !req.ex_is_load) begin
            rsp.fwd_sel_b = FWD_EX;
         end else if (m_b) begin
            rsp.fwd_sel_b = FWD_MEM;
         end
      end
      rsp.stall_res    = (active && (alu_stall || br_stall))
                       || req.ex_stop_fetch || req.mem_stop_fetch;
      rsp.branch_wait  = active && be_any;
      rsp.branch_fwd_a = active && fwd_on && !be_any && !req.mem_is_load && bm_a;
      rsp.branch_fwd_b = active && fwd_on && !be_any && !req.mem_is_load && bm_b;
   end

endmodule
